/* hdl/scc_pkg.sv */
package scc_pkg;

  localparam int WORD_BITS = 64;
  localparam int SLOTS_DEF = 1024;
  localparam int MAX_ROOMS_DEF = 8;
  localparam int CAP_W = 4;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd6;

  localparam int OP_W = 2;
  localparam int START_W = 10;
  localparam int END_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic rd;
    logic wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic last_word;
    logic clr_done;
  } sts_t;

endpackage

/* hdl/scc_ctrl.sv */
module scc_ctrl
  import scc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_START;
        end
      end
      ST_START: begin
        state_d = sts_i.bad ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd_o.wr = 1'b1;
        state_d  = sts_i.last_word ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_rd_then_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> cmd_o.wr)
    else $error("read of a calendar row not followed by its write-back");

  a_wr_then_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr && !sts_i.last_word) |=> cmd_o.rd)
    else $error("range walk stopped before the last word");

  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> (state_q == ST_IDLE))
    else $error("item accepted while busy");

endmodule

/* hdl/scc_datapath.sv */
module scc_datapath
  import scc_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int MAX_ROOMS = MAX_ROOMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [CAP_W-1:0]   capacity_i,
  input  logic [OP_W-1:0]    opcode_i,
  input  logic [START_W-1:0] start_slot_i,
  input  logic [END_W-1:0]   end_slot_i,
  output logic               fits_o,
  output logic               bad_range_o
);

  localparam int CAL_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WW = (CAL_WORDS > 1) ? $clog2(CAL_WORDS) : 1;
  localparam int CW = $clog2(MAX_ROOMS + 1);
  localparam int ROW_W = MAX_ROOMS * WORD_BITS;
  localparam logic [WW-1:0] LAST_WORD = WW'(CAL_WORDS - 1);

  logic [ROW_W-1:0] mem_q [CAL_WORDS];
  logic [ROW_W-1:0] row_q;
  logic [ROW_W-1:0] row_new;

  logic [OP_W-1:0]    op_q;
  logic [START_W-1:0] a_q;
  logic [END_W-1:0]   b_q;
  logic [CW-1:0]      cap_q;
  logic [WW-1:0]      w_q;
  logic               fits_q;
  logic               fits_out_q;
  logic               bad_out_q;

  logic [31:0]          cap_full;
  logic [CW-1:0]        cap_sat;
  logic [31:0]          w0_full;
  logic [31:0]          w1_full;
  logic [WW-1:0]        w0;
  logic [WW-1:0]        w1;
  logic [END_W-1:0]     b_m1;
  logic [5:0]           lo;
  logic [5:0]           hi_idx;
  logic [WORD_BITS-1:0] mask;
  logic                 hit;
  logic                 bad;

  assign cap_full = ({{(32 - CAP_W){1'b0}}, capacity_i} > 32'(MAX_ROOMS))
                  ? 32'(MAX_ROOMS) : {{(32 - CAP_W){1'b0}}, capacity_i};
  assign cap_sat  = cap_full[CW-1:0];

  assign b_m1    = b_q - END_W'(1);
  assign w0_full = {{(32 - START_W){1'b0}}, a_q} >> 6;
  assign w1_full = {{(32 - END_W){1'b0}}, b_m1} >> 6;
  assign w0      = w0_full[WW-1:0];
  assign w1      = w1_full[WW-1:0];
  assign bad     = ({1'b0, a_q} >= b_q) || ({{(32 - END_W){1'b0}}, b_q} > 32'(SLOTS));

  assign lo     = (w_q == w0) ? a_q[5:0] : 6'd0;
  assign hi_idx = (w_q == w1) ? b_m1[5:0] : 6'd63;
  assign mask   = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (6'd63 - hi_idx));

  always_comb begin
    logic [WORD_BITS-1:0] below;
    logic [WORD_BITS-1:0] above;
    hit     = 1'b0;
    row_new = row_q;
    for (int j = 0; j < MAX_ROOMS; j++) begin
      below = (j == 0) ? {WORD_BITS{1'b1}} : row_q[(j > 0 ? j - 1 : 0)*WORD_BITS +: WORD_BITS];
      above = (j == MAX_ROOMS - 1) ? '0
            : row_q[(j < MAX_ROOMS - 1 ? j + 1 : j)*WORD_BITS +: WORD_BITS];
      if (32'(j + 1) == {{(32 - CW){1'b0}}, cap_q}) begin
        hit = |(row_q[j*WORD_BITS +: WORD_BITS] & mask);
      end
      case (op_q)
        OP_RESERVE: begin
          if (32'(j) < {{(32 - CW){1'b0}}, cap_q}) begin
            row_new[j*WORD_BITS +: WORD_BITS] = row_q[j*WORD_BITS +: WORD_BITS]
                                              | (mask & below);
          end
        end
        OP_RELEASE: begin
          row_new[j*WORD_BITS +: WORD_BITS] = row_q[j*WORD_BITS +: WORD_BITS]
                                            & ~(mask & ~above);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_q[w_q] <= '0;
    end else if (cmd_i.wr) begin
      mem_q[w_q] <= row_new;
    end
    if (cmd_i.rd) begin
      row_q <= mem_q[w_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else if (cmd_i.clr_step || cmd_i.wr) begin
      w_q <= w_q + WW'(1);
    end else if (cmd_i.accept) begin
      w_q <= WW'({{(32 - START_W){1'b0}}, start_slot_i} >> 6);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= opcode_i;
      a_q    <= start_slot_i;
      b_q    <= end_slot_i;
      cap_q  <= cap_sat;
      fits_q <= (cap_sat != '0);
    end else if (cmd_i.wr && hit) begin
      fits_q <= 1'b0;
    end
    if (cmd_i.out_load) begin
      fits_out_q <= bad ? 1'b0 : fits_q;
      bad_out_q  <= bad;
    end
  end

  assign sts_o.bad       = bad;
  assign sts_o.last_word = (w_q == w1);
  assign sts_o.clr_done  = (w_q == LAST_WORD);
  assign fits_o          = fits_out_q;
  assign bad_range_o     = bad_out_q;

endmodule

/* hdl/slot_capacity_calendar_top.sv */
// Slot capacity calendar: per-slot reservation counts with a room limit.
// Input words arrive on the s_axis channel and carry an opcode (check,
// reserve, release) and a half-open slot range; each word yields exactly
// one result word on m_axis with the fits flag seen before the operation
// and a bad_range flag. The capacity register sits at byte address 0 of
// the APB port and should only be written while the block is idle.
// Counts are stored as thermometer planes, one memory row per 64-slot
// word holding every plane of that word. An item walks the words of its
// range with one read and one write-back of a row per word: it passes
// the start state, a read and a modify state for each word, and the done
// state, in which the result register is loaded; a bad range goes from
// the start state straight to done. The next word is taken only once the
// block is back in idle, so items do not overlap. After reset a clearing
// pass zeroes the calendar one word at a time and s_axis_tready stays low
// until it ends. A new word is accepted while a result waits; the item
// then finishes and holds until the receiver takes that result.
module slot_capacity_calendar_top
  import scc_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int MAX_ROOMS = MAX_ROOMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode [1:0], start_slot [11:2], end_slot [22:12], zero [23]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fits [0], bad_range [1], zero [7:2]
  output logic [7:0]  m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t             cmd;
  sts_t             sts;
  logic [CAP_W-1:0] capacity_q;
  logic             fits;
  logic             bad_range;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity_q} : '0;

  scc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scc_datapath #(
    .SLOTS     (SLOTS),
    .MAX_ROOMS (MAX_ROOMS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .capacity_i   (capacity_q),
    .opcode_i     (s_axis_tdata[1:0]),
    .start_slot_i (s_axis_tdata[11:2]),
    .end_slot_i   (s_axis_tdata[22:12]),
    .fits_o       (fits),
    .bad_range_o  (bad_range)
  );

  assign m_axis_tdata = {6'd0, bad_range, fits};

endmodule

/* tb/sv/slot_capacity_calendar_top_tb.sv */
`timescale 1ns / 100ps

module slot_capacity_calendar_top_tb
  import scc_pkg::*;
();

  localparam int N_SLOTS = SLOTS_DEF;
  localparam int N_PLANES = MAX_ROOMS_DEF;
  localparam int N_WORDS = SLOTS_DEF / WORD_BITS;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [START_W-1:0] start_slot;
    logic [END_W-1:0]   end_slot;
  } booking_t;

  typedef struct packed {
    logic fits;
    logic bad_range;
  } answer_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // opcode [1:0], start_slot [11:2], end_slot [22:12], zero [23]
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // fits [0], bad_range [1], zero [7:2]
  logic [7:0]  m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  slot_capacity_calendar_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  logic [WORD_BITS-1:0] cal_plane [N_PLANES][N_WORDS] = '{default: '0};
  logic [CAP_W-1:0]     cfg_capacity = CAPACITY_RESET;

  booking_t pending[$];
  answer_t  answers_due[$];
  booking_t on_bus;

  int err_cnt = 0;
  int booked_cnt = 0;
  int answered_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  logic [15:0] ready_pat = '0;
  int pat_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    $display("%0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [WORD_BITS-1:0] range_mask(int w, int a, int b);
    int lo;
    int hi;
    logic [WORD_BITS-1:0] m;
    lo = (w == a / WORD_BITS) ? a % WORD_BITS : 0;
    hi = (w == (b - 1) / WORD_BITS) ? (b - 1) % WORD_BITS + 1 : WORD_BITS;
    m = '0;
    for (int k = lo; k < hi; k++) m[k] = 1'b1;
    return m;
  endfunction

  // Each slot's count is a thermometer over the planes: plane j set means count > j.
  function automatic answer_t book_slots(booking_t bk);
    answer_t r;
    int a;
    int b;
    int cap;
    logic [WORD_BITS-1:0] rem;
    logic [WORD_BITS-1:0] hit;
    a = int'(bk.start_slot);
    b = int'(bk.end_slot);
    r.fits = 1'b0;
    r.bad_range = 1'b0;
    if (a >= b || b > N_SLOTS) begin
      r.bad_range = 1'b1;
      return r;
    end
    cap = (int'(cfg_capacity) > N_PLANES) ? N_PLANES : int'(cfg_capacity);
    r.fits = (cap > 0);
    if (cap > 0) begin
      for (int w = a / WORD_BITS; w <= (b - 1) / WORD_BITS; w++)
        if (|(cal_plane[cap-1][w] & range_mask(w, a, b))) r.fits = 1'b0;
    end
    if (bk.op == OP_RESERVE) begin
      for (int w = a / WORD_BITS; w <= (b - 1) / WORD_BITS; w++) begin
        rem = range_mask(w, a, b);
        for (int j = 0; j < cap; j++) begin
          hit = rem & ~cal_plane[j][w];
          cal_plane[j][w] |= hit;
          rem &= ~hit;
        end
      end
    end else if (bk.op == OP_RELEASE) begin
      for (int w = a / WORD_BITS; w <= (b - 1) / WORD_BITS; w++) begin
        rem = range_mask(w, a, b);
        for (int j = N_PLANES - 1; j >= 0; j--) begin
          hit = rem & cal_plane[j][w];
          cal_plane[j][w] &= ~hit;
          rem &= ~hit;
        end
      end
    end
    return r;
  endfunction

  task automatic queue_booking(logic [OP_W-1:0] op, int a, int b);
    booking_t bk;
    bk.op = op;
    bk.start_slot = START_W'(a);
    bk.end_slot = END_W'(b);
    pending.push_back(bk);
    booked_cnt++;
  endtask

  task automatic queue_random(int n);
    int r;
    int a;
    int b;
    int len;
    logic [OP_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_RESERVE;
      else if (r < 70) op = OP_RELEASE;
      else if (r < 95) op = OP_CHECK;
      else op = OP_SPARE;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        a = $urandom_range(0, N_SLOTS - 1);
        b = $urandom_range(0, a);
      end else if (r < 10) begin
        a = $urandom_range(0, N_SLOTS - 1);
        b = $urandom_range(N_SLOTS + 1, 2 * N_SLOTS - 1);
      end else begin
        a = (r < 55) ? $urandom_range(0, 255) : $urandom_range(0, N_SLOTS - 1);
        if (r < 20) a = a & ~(WORD_BITS - 1);
        len = $urandom_range(0, 99);
        if (len < 70) len = $urandom_range(1, 70);
        else if (len < 95) len = $urandom_range(1, 400);
        else len = $urandom_range(1, N_SLOTS);
        b = (a + len > N_SLOTS) ? N_SLOTS : a + len;
        if (r < 20 && b < N_SLOTS && b > a + WORD_BITS) b = b & ~(WORD_BITS - 1);
      end
      queue_booking(op, a, b);
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (answered_cnt != booked_cnt);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(int value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_capacity = CAP_W'(value);
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata[CAP_W-1:0] !== cfg_capacity)
      report($sformatf("capacity read back %0d, expected %0d",
                       prdata[CAP_W-1:0], cfg_capacity));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) answers_due.push_back(book_slots(on_bus));
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        on_bus = pending.pop_front();
        s_axis_tdata <= {1'b0, on_bus.end_slot, on_bus.start_slot, on_bus.op};
        s_axis_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_due.size() == 0) begin
          report($sformatf("result word %b arrived with nothing expected", m_axis_tdata));
        end else begin
          want = answers_due.pop_front();
          if (m_axis_tdata[0] !== want.fits)
            report($sformatf("result %0d: fits %b, expected %b",
                             answered_cnt, m_axis_tdata[0], want.fits));
          if (m_axis_tdata[1] !== want.bad_range)
            report($sformatf("result %0d: bad_range %b, expected %b",
                             answered_cnt, m_axis_tdata[1], want.bad_range));
          answered_cnt++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_reqs != hold_done) begin
        hold_done++;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          ready_pat = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
          pat_left = 16;
        end
        m_axis_tready <= ready_pat[pat_left-1];
        pat_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d results seen",
               cycle_cnt, answered_cnt, booked_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_booking(OP_CHECK, 0, N_SLOTS);
    queue_booking(OP_RESERVE, 0, 1);
    queue_booking(OP_RESERVE, N_SLOTS - 1, N_SLOTS);
    queue_booking(OP_RESERVE, 0, N_SLOTS);
    queue_booking(OP_CHECK, 0, N_SLOTS);
    queue_booking(OP_RELEASE, 0, N_SLOTS);
    queue_booking(OP_RELEASE, 0, N_SLOTS);
    queue_booking(OP_RELEASE, 512, 576);
    for (int k = 0; k < 7; k++) queue_booking(OP_RESERVE, 60, 70);
    queue_booking(OP_CHECK, 60, 70);
    queue_booking(OP_SPARE, 60, 70);
    queue_booking(OP_CHECK, 5, 5);
    queue_booking(OP_RESERVE, 10, 3);
    queue_booking(OP_RESERVE, 1000, N_SLOTS + 1);
    queue_booking(OP_RELEASE, N_SLOTS - 1, 2 * N_SLOTS - 1);
    queue_booking(OP_RESERVE, 0, WORD_BITS);
    queue_random(300);
    drain();

    write_capacity(N_PLANES);
    queue_random(250);
    hold_reqs++;
    drain();

    write_capacity(1);
    queue_random(250);
    drain();

    write_capacity(0);
    queue_booking(OP_RESERVE, 0, WORD_BITS);
    queue_booking(OP_RELEASE, 60, 70);
    queue_booking(OP_CHECK, 60, 70);
    queue_random(100);
    drain();

    write_capacity(15);
    queue_random(200);
    drain();

    write_capacity(2);
    queue_booking(OP_CHECK, 0, 256);
    queue_booking(OP_RESERVE, 0, 256);
    queue_booking(OP_RELEASE, 0, 256);
    queue_random(250);
    drain();

    write_capacity(9);
    queue_random(100);
    drain();

    repeat (40) @(posedge clk_i);
    if (answers_due.size() != 0)
      report($sformatf("%0d results never arrived", answers_due.size()));
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* slot_capacity_calendar_top.f */
hdl/scc_pkg.sv
hdl/scc_ctrl.sv
hdl/scc_datapath.sv
hdl/slot_capacity_calendar_top.sv
tb/sv/slot_capacity_calendar_top_tb.sv
